// ----- sv/spv_pkg.sv -----
// Shared types, constants and helpers of the sample playback voice.
`timescale 1ns / 1ps

package spv_pkg;

  localparam int DefSampleDepth = 65536;
  localparam int DefChannels    = 2;
  localparam int DefSampleBits  = 16;
  localparam int DefMaxBlock    = 4096;

  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 17;

  localparam logic [CfgIdxW-1:0] REG_SAMPLE_LENGTH = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_CHANNEL_COUNT = 1'b1;

  localparam logic [16:0] Q_ONE = 17'h10000;
  localparam logic [23:0] RATIO_ONE = 24'h010000;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_START  = 2'd1,
    OP_RENDER = 2'd2,
    OP_QUIT   = 2'd3
  } op_e;

  typedef struct packed {
    logic cap0;
    logic cap1;
    logic mix;
    logic scale;
    logic fin;
  } lane_ctrl_t;

  function automatic logic [16:0] clamp_one(input logic [16:0] v);
    clamp_one = (v > Q_ONE) ? Q_ONE : v;
  endfunction

endpackage

// ----- sv/spv_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module spv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/spv_div.sv -----
// Restoring divider, one quotient bit per cycle, result held until the next start.
`timescale 1ns / 1ps

module spv_div #(
  parameter int DVW = 49,
  parameter int DSW = 33
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [DVW-1:0] dividend_i,
  input  logic [DSW-1:0] divisor_i,
  output logic           busy_o,
  output logic [DVW-1:0] quot_o
);

  localparam int CntW = $clog2(DVW + 1);

  logic [DVW-1:0]  quot_q, quot_d;
  logic [DSW-1:0]  rem_q, rem_d, dsr_q, dsr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [DSW:0]    trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q, quot_q[DVW-1]};
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
      cnt_d  = CntW'(DVW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dsr_q}) begin
        rem_d  = DSW'(trial - {1'b0, dsr_q});
        quot_d = {quot_q[DVW-2:0], 1'b1};
      end else begin
        rem_d  = trial[DSW-1:0];
        quot_d = {quot_q[DVW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

endmodule

// ----- sv/spv_lane.sv -----
// One channel lane: sample memory, interpolation and gain scaling with saturation.
`timescale 1ns / 1ps

module spv_lane #(
  parameter int SAMPLE_DEPTH = 65536,
  parameter int SAMPLE_BITS  = 16
) (
  input  logic                            clk_i,
  input  logic                            we_i,
  input  logic [$clog2(SAMPLE_DEPTH)-1:0] waddr_i,
  input  logic signed [15:0]              wdata_i,
  input  logic [$clog2(SAMPLE_DEPTH)-1:0] raddr_i,
  input  spv_pkg::lane_ctrl_t             ctrl_i,
  input  logic [15:0]                     frac_i,
  input  logic [16:0]                     gain_i,
  output logic signed [15:0]              res_o
);

  import spv_pkg::*;

  localparam int SB  = SAMPLE_BITS;
  localparam int VW  = SB + 18;
  localparam int PHW = SB + 20;
  localparam int PWD = SB + 37;
  localparam int QW  = SB + 5;
  localparam int LIM = (SB < 16) ? SB : 16;
  localparam logic signed [QW-1:0] HI = QW'((1 << (LIM - 1)) - 1);
  localparam logic signed [QW-1:0] LO = -HI - QW'(1);

  logic signed [SB-1:0]  wsat;
  logic signed [SB-1:0]  rdata;
  logic signed [SB-1:0]  s0_q, s1_q;
  logic signed [SB:0]    dif;
  logic signed [VW-1:0]  v_d, v_q;
  logic signed [PHW-1:0] ph_q;
  logic [32:0]           pl_q;
  logic signed [PWD-1:0] prod;
  logic signed [QW-1:0]  qv;
  logic signed [15:0]    res_q;

  generate
    if (SB >= 16) begin : g_wide
      assign wsat = SB'(wdata_i);
    end else begin : g_narrow
      localparam logic signed [15:0] WHI = 16'((1 << (SB - 1)) - 1);
      localparam logic signed [15:0] WLO = -WHI - 16'sd1;
      always_comb begin
        if (wdata_i > WHI) begin
          wsat = SB'(WHI);
        end else if (wdata_i < WLO) begin
          wsat = SB'(WLO);
        end else begin
          wsat = SB'(wdata_i);
        end
      end
    end
  endgenerate

  spv_ram #(
    .WIDTH(SB),
    .DEPTH(SAMPLE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we_i),
    .waddr_i(waddr_i),
    .wdata_i(wsat),
    .raddr_i(raddr_i),
    .rdata_o(rdata)
  );

  assign dif  = {s1_q[SB-1], s1_q} - {s0_q[SB-1], s0_q};
  assign v_d  = ($signed(VW'(s0_q)) <<< 16) + dif * $signed({1'b0, frac_i});
  assign prod = ($signed(PWD'(ph_q)) <<< 16) + $signed({1'b0, pl_q});
  assign qv   = $signed(prod[PWD-1:32]);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.cap0) begin
      s0_q <= rdata;
    end
    if (ctrl_i.cap1) begin
      s1_q <= rdata;
    end
    if (ctrl_i.mix) begin
      v_q <= v_d;
    end
    if (ctrl_i.scale) begin
      ph_q <= $signed(v_q[VW-1:16]) * $signed({1'b0, gain_i});
      pl_q <= v_q[15:0] * gain_i;
    end
    if (ctrl_i.fin) begin
      if (qv > HI) begin
        res_q <= 16'(HI);
      end else if (qv < LO) begin
        res_q <= 16'(LO);
      end else begin
        res_q <= 16'(qv);
      end
    end
  end

  assign res_o = res_q;

endmodule

// ----- sv/sample_playback_voice.sv -----
// Top level of the sample playback voice: sequencer, shared divider, lanes and merge.
//
//   Channel  | Direction | Signals
//   ---------+-----------+-------------------------------------------------------
//   input    | in        | in_valid_i / in_ready_o, operation_i .. block_length_i
//   result   | out       | out_valid_o / out_ready_i, left_out_o, right_out_o,
//            |           | active_o
//   config   | in        | cfg_we_i, cfg_index_i, cfg_data_i
//
// One item is worked at a time; a start or a render can wait on the shared
// 49-step divider. Reset clears the voice state but not the sample memory.
// A finished result waits in the output register while the next item is taken;
// the sequencer stalls only if a second result is ready before the first transfer.
`timescale 1ns / 1ps

module sample_playback_voice #(
  parameter int SAMPLE_DEPTH = spv_pkg::DefSampleDepth,
  parameter int CHANNELS     = spv_pkg::DefChannels,
  parameter int SAMPLE_BITS  = spv_pkg::DefSampleBits,
  parameter int MAX_BLOCK    = spv_pkg::DefMaxBlock
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [spv_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [spv_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   operation_i,
  input  logic [15:0]                  index_i,
  input  logic signed [15:0]           left_in_i,
  input  logic signed [15:0]           right_in_i,
  input  logic [15:0]                  start_fraction_i,
  input  logic [16:0]                  end_fraction_i,
  input  logic [16:0]                  attack_fraction_i,
  input  logic [16:0]                  decay_fraction_i,
  input  logic [16:0]                  velocity_i,
  input  logic [23:0]                  rate_i,
  input  logic [16:0]                  gain_i,
  input  logic [12:0]                  block_length_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [15:0]           left_out_o,
  output logic signed [15:0]           right_out_o,
  output logic                         active_o
);

  import spv_pkg::*;

  localparam int AW   = $clog2(SAMPLE_DEPTH);
  localparam int PW   = $clog2(SAMPLE_DEPTH + 1);
  localparam int POSW = PW + 16;
  localparam int BLKW = $clog2(MAX_BLOCK + 1);
  localparam int WW   = 50;
  localparam int DVW  = 49;
  localparam int DSW  = POSW;
  localparam logic [WW-1:0] POS_SAT = WW'(64'h1_FFFF_FFFF);
  localparam logic [WW-1:0] FRAME   = WW'(65536);

  typedef enum logic [23:0] {
    S_IDLE   = 24'h000001,
    S_LOAD   = 24'h000002,
    S_QUIT   = 24'h000004,
    S_ST1    = 24'h000008,
    S_ST2    = 24'h000010,
    S_ATK    = 24'h000020,
    S_ATKW   = 24'h000040,
    S_DEC    = 24'h000080,
    S_DECW   = 24'h000100,
    S_RATIO  = 24'h000200,
    S_POS    = 24'h000400,
    S_NP     = 24'h000800,
    S_RD0    = 24'h001000,
    S_RD1    = 24'h002000,
    S_ENV1   = 24'h004000,
    S_ENV2   = 24'h008000,
    S_DIVW   = 24'h010000,
    S_G1     = 24'h020000,
    S_G2     = 24'h040000,
    S_L1     = 24'h080000,
    S_L2     = 24'h100000,
    S_L3     = 24'h200000,
    S_COMMIT = 24'h400000,
    S_DONE   = 24'h800000
  } state_e;

  typedef enum logic [1:0] {
    ENV_FULL = 2'd0,
    ENV_ATT  = 2'd1,
    ENV_DEC  = 2'd2
  } env_e;

  state_e state_q, state_d;
  logic   playing_q, playing_d, out_valid_q, out_valid_d;
  logic [16:0] sl_q, sl_d;
  logic [1:0]  cc_q, cc_d;
  logic [POSW-1:0] pp_q, pp_d, ap_q, ap_d, dp_q, dp_d;
  logic [PW-1:0]   startp_q, startp_d, endp_q, endp_d;
  logic [31:0]     arec_q, arec_d, drec_q, drec_d;
  logic [16:0]     vel_q, vel_d, pg_q, pg_d;
  logic [23:0]     base_q, base_d;

  logic [15:0]     idx_q, idx_d;
  logic signed [15:0] lin_q, lin_d, rin_q, rin_d;
  logic [15:0]     sf_q, sf_d;
  logic [16:0]     ef_q, ef_d, af_q, af_d, df_q, df_d, vin_q, vin_d, gain_q, gain_d;
  logic [23:0]     rate_q, rate_d;
  logic [BLKW-1:0] blk_q, blk_d;
  logic            zero_q, zero_d, endhit_q, endhit_d;
  logic [31:0]     ratio_q, ratio_d;
  logic [32:0]     num_q, num_d;
  logic [POSW-1:0] pos_q, pos_d, np_q, np_d;
  env_e            mode_q, mode_d;
  logic [16:0]     r_q, r_d, env_q, env_d, lg_q, lg_d, vg_q, vg_d, g_q, g_d;
  logic signed [15:0] lo_q, lo_d, ro_q, ro_d;
  logic            act_q, act_d;

  logic            div_start, div_busy;
  logic [DVW-1:0]  div_dividend, div_quot;
  logic [DSW-1:0]  div_divisor;
  logic            lane_we;
  logic [AW-1:0]   lane_waddr, lane_raddr;
  lane_ctrl_t      lane_ctrl;
  logic signed [15:0] lane_res [2];

  logic [PW-1:0]   len;
  logic [BLKW-1:0] blk_in;
  logic [16:0]     blk_in17;
  logic [POSW-1:0] s16, e16, env_dist;
  logic [WW-1:0]   pos_w, np_w;
  logic [PW+16:0]  span_att, span_dec;
  logic [PW-1:0]   span;
  logic [POSW+31:0] eprod;
  logic [33:0]     gprod;
  logic [1:0]      nch;

  assign in_ready_o = (state_q == S_IDLE);
  assign s16 = {startp_q, 16'b0};
  assign e16 = {endp_q, 16'b0};

  always_comb begin
    if ({15'b0, sl_q} > 32'(SAMPLE_DEPTH)) begin
      len = PW'(SAMPLE_DEPTH);
    end else if (sl_q == '0) begin
      len = PW'(1);
    end else begin
      len = PW'(sl_q);
    end
    if (block_length_i == '0) begin
      blk_in = BLKW'(1);
    end else if ({4'b0, block_length_i} > 17'(MAX_BLOCK)) begin
      blk_in = BLKW'(MAX_BLOCK);
    end else begin
      blk_in = BLKW'(block_length_i);
    end
    blk_in17 = 17'(blk_in);
    if (cc_q == 2'd0) begin
      nch = 2'd1;
    end else if (32'(cc_q) > 32'(CHANNELS)) begin
      nch = 2'(CHANNELS);
    end else begin
      nch = cc_q;
    end
    span     = (endp_q > startp_q) ? (endp_q - startp_q) : '0;
    span_att = (PW + 17)'(span) * (PW + 17)'(af_q);
    span_dec = (PW + 17)'(span) * (PW + 17)'(df_q);
    pos_w    = WW'(pp_q) + WW'(idx_q) * WW'(ratio_q);
    np_w     = WW'(pp_q) + WW'(blk_q) * WW'(ratio_q);
    if (mode_q == ENV_ATT) begin
      env_dist = (pos_q > s16) ? (pos_q - s16) : '0;
      eprod    = (POSW + 32)'(env_dist) * (POSW + 32)'(arec_q);
    end else begin
      env_dist = e16 - pos_q;
      eprod    = (POSW + 32)'(env_dist) * (POSW + 32)'(drec_q);
    end
    gprod = 34'(vg_q) * 34'(env_q);
  end

  always_comb begin
    state_d = state_q;   playing_d = playing_q; out_valid_d = out_valid_q;
    sl_d = sl_q;         cc_d = cc_q;           pp_d = pp_q;
    ap_d = ap_q;         dp_d = dp_q;           startp_d = startp_q;
    endp_d = endp_q;     arec_d = arec_q;       drec_d = drec_q;
    vel_d = vel_q;       pg_d = pg_q;           base_d = base_q;
    idx_d = idx_q;       lin_d = lin_q;         rin_d = rin_q;
    sf_d = sf_q;         ef_d = ef_q;           af_d = af_q;
    df_d = df_q;         vin_d = vin_q;         gain_d = gain_q;
    rate_d = rate_q;     blk_d = blk_q;         zero_d = zero_q;
    endhit_d = endhit_q; ratio_d = ratio_q;     num_d = num_q;
    pos_d = pos_q;       np_d = np_q;           mode_d = mode_q;
    r_d = r_q;           env_d = env_q;         lg_d = lg_q;
    vg_d = vg_q;         g_d = g_q;             lo_d = lo_q;
    ro_d = ro_q;         act_d = act_q;
    div_start = 1'b0;    div_dividend = '0;     div_divisor = '0;
    lane_we = 1'b0;      lane_waddr = AW'(idx_q);
    lane_raddr = pos_q[AW+15:16];
    lane_ctrl = '0;

    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_SAMPLE_LENGTH: sl_d = cfg_data_i;
        REG_CHANNEL_COUNT: cc_d = cfg_data_i[1:0];
        default: ;
      endcase
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          idx_d  = index_i;
          lin_d  = left_in_i;
          rin_d  = right_in_i;
          sf_d   = start_fraction_i;
          ef_d   = clamp_one(end_fraction_i);
          af_d   = clamp_one(attack_fraction_i);
          df_d   = clamp_one(decay_fraction_i);
          vin_d  = clamp_one(velocity_i);
          rate_d = rate_i;
          gain_d = clamp_one(gain_i);
          blk_d  = blk_in;
          zero_d = 1'b1;
          case (op_e'(operation_i))
            OP_LOAD:  state_d = S_LOAD;
            OP_START: state_d = S_ST1;
            OP_QUIT:  state_d = S_QUIT;
            OP_RENDER: begin
              if (playing_q && ({1'b0, index_i} < blk_in17)) begin
                zero_d  = 1'b0;
                state_d = S_RATIO;
              end else begin
                state_d = S_DONE;
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_LOAD: begin
        lane_we = ({16'b0, idx_q} < 32'(SAMPLE_DEPTH));
        state_d = S_DONE;
      end
      S_QUIT: begin
        playing_d = 1'b0;
        pp_d      = '0;
        base_d    = RATIO_ONE;
        state_d   = S_DONE;
      end
      S_ST1: begin
        endp_d   = PW'(((PW + 17)'(len) * (PW + 17)'(ef_q)) >> 16);
        startp_d = PW'(((PW + 16)'(len) * (PW + 16)'(sf_q)) >> 16);
        state_d  = S_ST2;
      end
      S_ST2: begin
        pp_d      = s16;
        ap_d      = s16 + POSW'(span_att);
        dp_d      = s16 + POSW'(span_dec);
        vel_d     = vin_q;
        base_d    = rate_q;
        pg_d      = Q_ONE;
        playing_d = 1'b1;
        state_d   = S_ATK;
      end
      S_ATK: begin
        if (ap_q == s16) begin
          arec_d  = '0;
          state_d = S_DEC;
        end else begin
          div_start    = 1'b1;
          div_dividend = DVW'(1) << 48;
          div_divisor  = ap_q - s16;
          state_d      = S_ATKW;
        end
      end
      S_ATKW: begin
        if (!div_busy) begin
          arec_d  = (|div_quot[DVW-1:32]) ? 32'hFFFF_FFFF : div_quot[31:0];
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        if (dp_q < e16) begin
          div_start    = 1'b1;
          div_dividend = DVW'(1) << 48;
          div_divisor  = e16 - dp_q;
          state_d      = S_DECW;
        end else begin
          drec_d  = '0;
          state_d = S_DONE;
        end
      end
      S_DECW: begin
        if (!div_busy) begin
          drec_d  = (|div_quot[DVW-1:32]) ? 32'hFFFF_FFFF : div_quot[31:0];
          state_d = S_DONE;
        end
      end
      S_RATIO: begin
        ratio_d = 32'((48'(base_q) * 48'(rate_q)) >> 16);
        num_d   = 33'(34'(pg_q) * 34'(17'(blk_q) - {1'b0, idx_q})
                    + 34'(gain_q) * 34'(idx_q));
        state_d = S_POS;
      end
      S_POS: begin
        pos_d        = POSW'(pos_w);
        zero_d       = (pos_w + FRAME >= WW'(e16));
        div_start    = 1'b1;
        div_dividend = DVW'(num_q);
        div_divisor  = DSW'(blk_q);
        state_d      = S_NP;
      end
      S_NP: begin
        if (np_w > POS_SAT) begin
          np_d     = POSW'(POS_SAT);
          endhit_d = (POS_SAT + FRAME >= WW'(e16));
        end else begin
          np_d     = POSW'(np_w);
          endhit_d = (np_w + FRAME >= WW'(e16));
        end
        if (pos_q <= ap_q) begin
          mode_d = (ap_q != s16) ? ENV_ATT : ENV_FULL;
        end else if (pos_q >= dp_q) begin
          mode_d = ENV_DEC;
        end else begin
          mode_d = ENV_FULL;
        end
        state_d = zero_q ? S_COMMIT : S_RD0;
      end
      S_RD0: begin
        state_d = S_RD1;
      end
      S_RD1: begin
        lane_raddr     = pos_q[AW+15:16] + AW'(1);
        lane_ctrl.cap0 = 1'b1;
        state_d        = S_ENV1;
      end
      S_ENV1: begin
        lane_ctrl.cap1 = 1'b1;
        r_d     = (|eprod[POSW+31:48]) ? Q_ONE : clamp_one(eprod[48:32]);
        state_d = S_ENV2;
      end
      S_ENV2: begin
        case (mode_q)
          ENV_ATT: env_d = r_q;
          ENV_DEC: env_d = (drec_q == '0) ? '0 : 17'((34'(r_q) * 34'(r_q)) >> 16);
          default: env_d = Q_ONE;
        endcase
        state_d = S_DIVW;
      end
      S_DIVW: begin
        if (!div_busy) begin
          lg_d    = div_quot[16:0];
          state_d = S_G1;
        end
      end
      S_G1: begin
        vg_d    = 17'((34'(vel_q) * 34'(lg_q)) >> 16);
        state_d = S_G2;
      end
      S_G2: begin
        g_d     = gprod[32:16];
        state_d = S_L1;
      end
      S_L1: begin
        lane_ctrl.mix = 1'b1;
        state_d       = S_L2;
      end
      S_L2: begin
        lane_ctrl.scale = 1'b1;
        state_d         = S_L3;
      end
      S_L3: begin
        lane_ctrl.fin = 1'b1;
        state_d       = S_COMMIT;
      end
      S_COMMIT: begin
        if (({1'b0, idx_q} + 17'd1) == 17'(blk_q)) begin
          pg_d = gain_q;
          if (endhit_q) begin
            pp_d      = e16;
            playing_d = 1'b0;
            vel_d     = '0;
          end else begin
            pp_d = np_q;
          end
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          lo_d        = zero_q ? '0 : lane_res[0];
          ro_d        = (zero_q || nch < 2'd2) ? '0 : lane_res[1];
          act_d       = playing_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  spv_div #(
    .DVW(DVW),
    .DSW(DSW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .busy_o    (div_busy),
    .quot_o    (div_quot)
  );

  generate
    for (genvar ch = 0; ch < 2; ch++) begin : g_lane
      if (ch < CHANNELS) begin : g_on
        spv_lane #(
          .SAMPLE_DEPTH(SAMPLE_DEPTH),
          .SAMPLE_BITS (SAMPLE_BITS)
        ) u_lane (
          .clk_i  (clk_i),
          .we_i   (lane_we),
          .waddr_i(lane_waddr),
          .wdata_i((ch == 0) ? lin_q : rin_q),
          .raddr_i(lane_raddr),
          .ctrl_i (lane_ctrl),
          .frac_i (pos_q[15:0]),
          .gain_i (g_q),
          .res_o  (lane_res[ch])
        );
      end else begin : g_off
        assign lane_res[ch] = '0;
      end
    end
  endgenerate

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      playing_q   <= 1'b0;
      out_valid_q <= 1'b0;
      sl_q        <= 17'h10000;
      cc_q        <= 2'd2;
      pp_q        <= '0;
      ap_q        <= '0;
      dp_q        <= '0;
      startp_q    <= '0;
      endp_q      <= '0;
      arec_q      <= '0;
      drec_q      <= '0;
      vel_q       <= '0;
      pg_q        <= Q_ONE;
      base_q      <= RATIO_ONE;
    end else begin
      state_q     <= state_d;
      playing_q   <= playing_d;
      out_valid_q <= out_valid_d;
      sl_q        <= sl_d;
      cc_q        <= cc_d;
      pp_q        <= pp_d;
      ap_q        <= ap_d;
      dp_q        <= dp_d;
      startp_q    <= startp_d;
      endp_q      <= endp_d;
      arec_q      <= arec_d;
      drec_q      <= drec_d;
      vel_q       <= vel_d;
      pg_q        <= pg_d;
      base_q      <= base_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    lin_q    <= lin_d;
    rin_q    <= rin_d;
    sf_q     <= sf_d;
    ef_q     <= ef_d;
    af_q     <= af_d;
    df_q     <= df_d;
    vin_q    <= vin_d;
    gain_q   <= gain_d;
    rate_q   <= rate_d;
    blk_q    <= blk_d;
    zero_q   <= zero_d;
    endhit_q <= endhit_d;
    ratio_q  <= ratio_d;
    num_q    <= num_d;
    pos_q    <= pos_d;
    np_q     <= np_d;
    mode_q   <= mode_d;
    r_q      <= r_d;
    env_q    <= env_d;
    lg_q     <= lg_d;
    vg_q     <= vg_d;
    g_q      <= g_d;
    lo_q     <= lo_d;
    ro_q     <= ro_d;
    act_q    <= act_d;
  end

  assign out_valid_o = out_valid_q;
  assign left_out_o  = lo_q;
  assign right_out_o = ro_q;
  assign active_o    = act_q;

endmodule

// ----- sim/sample_playback_voice_check.sv -----
// Checker of the sample playback voice: predicts each result from the input transfers and compares.
`timescale 1ns / 1ps

module sample_playback_voice_check (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [spv_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [spv_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic [1:0]                   operation_i,
  input  logic [15:0]                  index_i,
  input  logic signed [15:0]           left_in_i,
  input  logic signed [15:0]           right_in_i,
  input  logic [15:0]                  start_fraction_i,
  input  logic [16:0]                  end_fraction_i,
  input  logic [16:0]                  attack_fraction_i,
  input  logic [16:0]                  decay_fraction_i,
  input  logic [16:0]                  velocity_i,
  input  logic [23:0]                  rate_i,
  input  logic [16:0]                  gain_i,
  input  logic [12:0]                  block_length_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic signed [15:0]           left_out_i,
  input  logic signed [15:0]           right_out_i,
  input  logic                         active_i,
  output int                           fail_count_o,
  output int                           pending_o,
  output int                           checked_o
);

  import spv_pkg::*;

  typedef struct {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               active;
  } frame_t;

  frame_t frames_due[$];

  logic [16:0]        length_reg;
  logic [1:0]         channels_reg;
  logic signed [15:0] mem_left [0:65535];
  logic signed [15:0] mem_right[0:65535];
  longint unsigned    head_pos, attack_pos, decay_pos, start_frame, end_frame;
  longint unsigned    attack_recip, decay_recip, note_vel, base_ratio, last_gain;
  bit                 playing;

  function automatic longint unsigned clamp_q(input longint unsigned v);
    return (v > 65536) ? 65536 : v;
  endfunction

  function automatic longint unsigned recip_q48(input longint unsigned d);
    longint unsigned r;
    if (d == 0) return 0;
    r = (64'd1 << 48) / d;
    return (r > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : r;
  endfunction

  function automatic logic signed [15:0] sat16(input longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  task automatic voice_step(output frame_t fr);
    longint unsigned len, span, s16, e16, blk, gain, ratio, p, y, f, lg, env, rr, g, np;
    longint unsigned offset, nch, idx;
    longint s0, s1, v, fs, gs;
    fr.left = '0;
    fr.right = '0;
    idx = index_i;
    case (operation_i)
      OP_LOAD: begin
        mem_left[index_i] = left_in_i;
        mem_right[index_i] = right_in_i;
      end
      OP_START: begin
        len = (length_reg == 0) ? 1 : length_reg;
        if (len > 65536) len = 65536;
        end_frame = (len * clamp_q(end_fraction_i)) >> 16;
        start_frame = (len * start_fraction_i) >> 16;
        span = (end_frame > start_frame) ? end_frame - start_frame : 0;
        s16 = start_frame << 16;
        e16 = end_frame << 16;
        head_pos = s16;
        attack_pos = s16 + span * clamp_q(attack_fraction_i);
        decay_pos = s16 + span * clamp_q(decay_fraction_i);
        attack_recip = recip_q48(attack_pos - s16);
        decay_recip = (decay_pos < e16) ? recip_q48(e16 - decay_pos) : 0;
        note_vel = clamp_q(velocity_i);
        base_ratio = rate_i;
        last_gain = 65536;
        playing = 1;
      end
      OP_QUIT: begin
        playing = 0;
        head_pos = 0;
        base_ratio = 65536;
      end
      default: begin
        if (playing) begin
          blk = block_length_i;
          if (blk < 1) blk = 1;
          if (blk > 4096) blk = 4096;
          gain = clamp_q(gain_i);
          ratio = (base_ratio * rate_i) >> 16;
          e16 = end_frame << 16;
          if (idx < blk) begin
            p = head_pos + idx * ratio;
            if (p + 65536 < e16) begin
              y = p >> 16;
              f = p & 64'hFFFF;
              lg = (last_gain * (blk - idx) + gain * idx) / blk;
              env = 65536;
              s16 = start_frame << 16;
              if (p <= attack_pos) begin
                if (attack_pos != s16) begin
                  offset = (p > s16) ? p - s16 : 0;
                  env = clamp_q((offset * attack_recip) >> 32);
                end
              end else if (p >= decay_pos) begin
                rr = clamp_q(((e16 - p) * decay_recip) >> 32);
                env = (decay_recip == 0) ? 0 : (rr * rr) >> 16;
              end
              g = (((note_vel * lg) >> 16) * env) >> 16;
              nch = (channels_reg < 1) ? 1 : channels_reg;
              fs = f;
              gs = g;
              s0 = mem_left[y[15:0]];
              s1 = (y + 1 < 65536) ? mem_left[y[15:0] + 16'd1] : 0;
              v = s0 * (65536 - fs) + s1 * fs;
              fr.left = sat16((v * gs) >>> 32);
              if (nch > 1) begin
                s0 = mem_right[y[15:0]];
                s1 = (y + 1 < 65536) ? mem_right[y[15:0] + 16'd1] : 0;
                v = s0 * (65536 - fs) + s1 * fs;
                fr.right = sat16((v * gs) >>> 32);
              end
            end
            if (idx + 1 == blk) begin
              np = head_pos + blk * ratio;
              if (np > 64'h1_FFFF_FFFF) np = 64'h1_FFFF_FFFF;
              last_gain = gain;
              head_pos = np;
              if (np + 65536 >= e16) begin
                head_pos = e16;
                playing = 0;
                note_vel = 0;
              end
            end
          end
        end
      end
    endcase
    fr.active = playing;
  endtask

  initial fail_count_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    frame_t fr, exp_fr;
    if (!rst_ni) begin
      length_reg = 17'd65536;
      channels_reg = 2'd2;
      head_pos = 0;
      attack_pos = 0;
      decay_pos = 0;
      start_frame = 0;
      end_frame = 0;
      attack_recip = 0;
      decay_recip = 0;
      note_vel = 0;
      base_ratio = 65536;
      last_gain = 65536;
      playing = 0;
      frames_due.delete();
      checked_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == REG_SAMPLE_LENGTH) length_reg = cfg_data_i;
        else if (cfg_index_i == REG_CHANNEL_COUNT) channels_reg = cfg_data_i[1:0];
      end
      if (in_valid_i && in_ready_i) begin
        voice_step(fr);
        frames_due.push_back(fr);
      end
      if (out_valid_i && out_ready_i) begin
        checked_o++;
        if (frames_due.size() == 0) begin
          fail_count_o++;
          $display("%0t: result transfer with nothing expected (left %0d right %0d active %0d)",
                   $time, left_out_i, right_out_i, active_i);
        end else begin
          exp_fr = frames_due.pop_front();
          if (left_out_i !== exp_fr.left) begin
            fail_count_o++;
            $display("%0t: left_out expected %0d, actual %0d", $time, exp_fr.left, left_out_i);
          end
          if (right_out_i !== exp_fr.right) begin
            fail_count_o++;
            $display("%0t: right_out expected %0d, actual %0d", $time, exp_fr.right,
                     right_out_i);
          end
          if (active_i !== exp_fr.active) begin
            fail_count_o++;
            $display("%0t: active expected %0d, actual %0d", $time, exp_fr.active, active_i);
          end
        end
      end
    end
    pending_o = frames_due.size();
  end

endmodule

// ----- sim/sample_playback_voice_test.sv -----
// Testbench top of the sample playback voice: stimulus, handshake pacing and the verdict.
`timescale 1ns / 1ps

module sample_playback_voice_test;
  import spv_pkg::*;

  typedef struct {
    logic [1:0]         op;
    logic [15:0]        index;
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic [15:0]        start_f;
    logic [16:0]        end_f;
    logic [16:0]        attack_f;
    logic [16:0]        decay_f;
    logic [16:0]        vel;
    logic [23:0]        rate;
    logic [16:0]        gain;
    logic [12:0]        blk;
  } item_t;

  logic                clk, rst_n, cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  logic                in_valid, in_ready, out_valid, out_ready, active;
  logic [1:0]          operation;
  logic [15:0]         index, start_fraction;
  logic signed [15:0]  left_in, right_in, left_out, right_out;
  logic [16:0]         end_fraction, attack_fraction, decay_fraction, velocity, gain;
  logic [23:0]         rate;
  logic [12:0]         block_length;
  int                  fail_count, pending, checked;
  int                  sent, frames_ready, length_used, idle_cycles, phase_items;
  bit                  calm, hold_req;

  int cfg_len[8] = '{64, 65536, 1, 100, 0, 200, 131071, 65536};
  int cfg_ch[8]  = '{2, 2, 1, 1, 0, 2, 3, 1};

  sample_playback_voice dut (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data), .in_valid_i(in_valid), .in_ready_o(in_ready),
    .operation_i(operation), .index_i(index), .left_in_i(left_in), .right_in_i(right_in),
    .start_fraction_i(start_fraction), .end_fraction_i(end_fraction),
    .attack_fraction_i(attack_fraction), .decay_fraction_i(decay_fraction),
    .velocity_i(velocity), .rate_i(rate), .gain_i(gain), .block_length_i(block_length),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .left_out_o(left_out),
    .right_out_o(right_out), .active_o(active)
  );

  sample_playback_voice_check checker_i (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data), .in_valid_i(in_valid), .in_ready_i(in_ready),
    .operation_i(operation), .index_i(index), .left_in_i(left_in), .right_in_i(right_in),
    .start_fraction_i(start_fraction), .end_fraction_i(end_fraction),
    .attack_fraction_i(attack_fraction), .decay_fraction_i(decay_fraction),
    .velocity_i(velocity), .rate_i(rate), .gain_i(gain), .block_length_i(block_length),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .left_out_i(left_out),
    .right_out_i(right_out), .active_i(active), .fail_count_o(fail_count),
    .pending_o(pending), .checked_o(checked)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= 4000) begin
        $display("Timeout: no transfer for %0d cycles", idle_cycles);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic item_t noise_item();
    item_t x;
    x.op = 2'($urandom);
    x.index = 16'($urandom);
    x.left = 16'($urandom);
    x.right = 16'($urandom);
    x.start_f = 16'($urandom);
    x.end_f = 17'($urandom);
    x.attack_f = 17'($urandom);
    x.decay_f = 17'($urandom);
    x.vel = 17'($urandom);
    x.rate = 24'($urandom);
    x.gain = 17'($urandom);
    x.blk = 13'($urandom);
    return x;
  endfunction

  function automatic logic [16:0] pick_q();
    case ($urandom_range(0, 4))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'($urandom_range(0, 131071));
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  task automatic send(input item_t x);
    repeat (calm ? 0 : $urandom_range(0, 11)) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    operation = x.op;
    index = x.index;
    left_in = x.left;
    right_in = x.right;
    start_fraction = x.start_f;
    end_fraction = x.end_f;
    attack_fraction = x.attack_f;
    decay_fraction = x.decay_f;
    velocity = x.vel;
    rate = x.rate;
    gain = x.gain;
    block_length = x.blk;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    sent++;
    phase_items++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] r, input int d);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = r;
    cfg_data = CfgDataW'(d);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic render(input int idx, input int rt, input int g, input int b);
    item_t x;
    x = noise_item();
    x.op = OP_RENDER;
    x.index = 16'(idx);
    x.rate = 24'(rt);
    x.gain = 17'(g);
    x.blk = 13'(b);
    send(x);
  endtask

  task automatic start_note(input int sf, input int ef, input int af, input int df,
                            input int v, input int rt);
    item_t x;
    x = noise_item();
    x.op = OP_START;
    x.start_f = 16'(sf);
    x.end_f = 17'(ef);
    x.attack_f = 17'(af);
    x.decay_f = 17'(df);
    x.vel = 17'(v);
    x.rate = 24'(rt);
    send(x);
  endtask

  task automatic quit_voice();
    item_t x;
    x = noise_item();
    x.op = OP_QUIT;
    send(x);
  endtask

  // Notes only reach frames below the loaded prefix of the memory.
  task automatic random_note();
    int ef, sf, nblk, b, rt, g;
    if (length_used <= frames_ready) ef = pick_q();
    else ef = $urandom_range(0, (frames_ready << 16) / length_used);
    sf = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                     : $urandom_range(0, (ef > 65535) ? 65535 : ef);
    start_note(sf, ef, pick_q(), pick_q(), pick_q(),
               ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(24'h4000, 24'h30000));
    nblk = $urandom_range(1, 10);
    repeat (nblk) begin
      b = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 6);
      rt = ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(24'h8000, 24'h20000);
      g = pick_q();
      if (b > 8 || b == 0) begin
        repeat ($urandom_range(1, 4)) render($urandom_range(0, 4095), rt, g, b);
        render((b == 0) ? 0 : ((b > 4096) ? 4095 : b - 1), rt, g, b);
      end else begin
        for (int i = 0; i < b; i++) render(i, rt, g, b);
      end
    end
  endtask

  task automatic random_noise();
    item_t x;
    x = noise_item();
    if (x.op == OP_START) x.op = OP_QUIT;
    send(x);
  endtask

  initial begin
    out_ready = 1'b0;
    wait (rst_n);
    forever begin
      if (hold_req) begin
        @(negedge clk);
        out_ready = 1'b0;
        repeat (800) @(negedge clk);
        hold_req = 1'b0;
      end
      repeat (calm ? 0 : $urandom_range(0, 11)) begin
        @(negedge clk);
        out_ready = 1'b0;
      end
      @(negedge clk);
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    item_t x;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    x = noise_item();
    operation = OP_QUIT;
    index = '0;
    left_in = '0;
    right_in = '0;
    start_fraction = '0;
    end_fraction = '0;
    attack_fraction = '0;
    decay_fraction = '0;
    velocity = '0;
    rate = '0;
    gain = '0;
    block_length = '0;
    sent = 0;
    idle_cycles = 0;
    calm = 1'b0;
    hold_req = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_SAMPLE_LENGTH, cfg_len[ph]);
      write_reg(REG_CHANNEL_COUNT, cfg_ch[ph]);
      length_used = (cfg_len[ph] == 0) ? 1 : ((cfg_len[ph] > 65536) ? 65536 : cfg_len[ph]);
      frames_ready = (length_used <= 128) ? length_used : 96;
      calm = (ph % 3 == 2);
      for (int a = 0; a < frames_ready; a++) begin
        x = noise_item();
        x.op = OP_LOAD;
        x.index = 16'(a);
        if (a % 7 == 1) x.left = -16'sd32768;
        if (a % 7 == 2) x.right = 16'sd32767;
        send(x);
      end
      if (ph == 0) begin
        render(0, 24'h10000, 65536, 4);
        quit_voice();
        start_note(0, 65536, 0, 65536, 65536, 24'h10000);
        render(0, 24'h10000, 0, 4);
        render(7, 24'h10000, 0, 4);
        for (int i = 1; i < 4; i++) render(i, 24'h10000, 65536, 4);
        start_note(0, 65536, 0, 65536, 65536, 24'h18000);
        for (int i = 0; i < 3; i++) render(i, 24'h10000, 40000, 3);
        start_note(0, 1024, 1, 131071, 131071, 24'h10000);
        render(0, 24'h100, 65536, 1);
        start_note(65535, 65536, 65536, 0, 0, 24'hFFFFFF);
        render(0, 24'hFFFFFF, 131071, 8191);
        start_note(1000, 60000, 30000, 40000, 50000, 24'hFFFFFF);
        render(4095, 24'hFFFFFF, 65536, 0);
        start_note(0, 65536, 20000, 50000, 65536, 24'h0);
        render(0, 24'h0, 65536, 2);
        quit_voice();
        render(0, 24'h10000, 65536, 1);
      end
      phase_items = 0;
      while (phase_items < 150) begin
        if (ph == 3 && phase_items > 60 && phase_items < 70) hold_req = 1'b1;
        if ($urandom_range(0, 3) != 0) random_note();
        else repeat ($urandom_range(1, 4)) random_noise();
      end
      drain();
    end

    $display("Covered 8 length and channel settings: %0d items sent, %0d results compared.",
             sent, checked);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
